// ===== hw/rtl/memoized_collatz_cache_assert.svh =====
// assertion macros for the memo cache checker
`ifndef MEMOIZED_COLLATZ_CACHE_ASSERT_SVH
`define MEMOIZED_COLLATZ_CACHE_ASSERT_SVH
`define MCC_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define MCC_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/mcc_pkg.sv =====
// shared constants of the memo cache
package mcc_pkg;
  localparam int Entries = 16;
  localparam int IdxW = $clog2(Entries);
  localparam int OccW = $clog2(Entries + 1);
  localparam int StepW = 12;
  localparam logic [StepW-1:0] StepMax = {StepW{1'b1}};
  localparam logic [0:0] CfgPolicy = 1'b0;
  localparam logic [0:0] CfgEntries = 1'b1;
  localparam logic PolicyLru = 1'b0;
  localparam logic [63:0] TripleLimit = 64'h5555_5555_5555_5554;
endpackage

// ===== hw/rtl/memoized_collatz_cache.sv =====
// memo cache of collatz step counts with lru or fifo replacement
// a hit scans the list from the front and under lru is then shifted to the front
// a miss scans the list, walks the trajectory, evicts while full and inserts, at the front
// under lru; one shared 64-bit add/shift unit does one step per cycle
// a zero item skips the lookup; one item at a time, next accepted once the result is taken
// synchronous active-low reset empties the store and clears the totals
module memoized_collatz_cache (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [30:0] in_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_steps,
  output logic        out_hit,
  output logic        out_saturated,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  localparam int E = mcc_pkg::Entries;
  localparam int IW = mcc_pkg::IdxW;
  localparam int OW = mcc_pkg::OccW;
  localparam int SW = mcc_pkg::StepW;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WALK, S_EVICT, S_SHIFT, S_DONE} state_t;

  state_t              state_r;
  logic [30:0]         key_r [E];
  logic [SW-1:0]       stp_r [E];
  logic [IW-1:0]       ord_r [E];
  logic [E-1:0]        vld_r;
  logic [OW-1:0]       occ_r, pos_r, cap_r;
  logic [31:0]         hits_r, miss_r;
  logic [63:0]         traj_r;
  logic [SW-1:0]       tally_r;
  logic                pol_r;
  logic [4:0]          eiu_r;
  logic [30:0]         num_r;
  logic [IW-1:0]       slot_r;
  logic                sat_r, hit_r;
  logic [IW-1:0]       free_slot;
  logic [OW-1:0]       ins_pos;

  assign cfg_ready = 1'b1;
  assign in_stall = (state_r != S_IDLE) || out_valid;

  always_comb begin
    free_slot = '0;
    for (int s = E - 1; s >= 0; s--) begin
      if (!vld_r[s]) free_slot = IW'(s);
    end
  end

  assign ins_pos = (pol_r == mcc_pkg::PolicyLru) ? '0 : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= '0;
      occ_r <= '0;
      hits_r <= '0;
      miss_r <= '0;
      pol_r <= 1'b0;
      eiu_r <= 5'd16;
      out_valid <= 1'b0;
      traj_r <= '0;
      tally_r <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == mcc_pkg::CfgPolicy) pol_r <= cfg_data[0];
        else eiu_r <= cfg_data;
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            num_r <= in_number;
            pos_r <= '0;
            if (in_number == '0) begin
              out_steps <= '0;
              out_hit <= 1'b0;
              out_saturated <= 1'b1;
              out_hit_count <= hits_r;
              out_miss_count <= miss_r;
              out_valid <= 1'b1;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (pos_r >= occ_r) begin
            miss_r <= miss_r + 32'd1;
            traj_r <= {33'd0, num_r};
            tally_r <= '0;
            sat_r <= 1'b0;
            hit_r <= 1'b0;
            if (eiu_r == 5'd0) cap_r <= OW'(1);
            else if (32'(eiu_r) > E) cap_r <= OW'(E);
            else cap_r <= OW'(eiu_r);
            state_r <= S_WALK;
          end else if (key_r[ord_r[pos_r[IW-1:0]]] == num_r) begin
            hits_r <= hits_r + 32'd1;
            hit_r <= 1'b1;
            slot_r <= ord_r[pos_r[IW-1:0]];
            out_steps <= stp_r[ord_r[pos_r[IW-1:0]]];
            out_saturated <= stp_r[ord_r[pos_r[IW-1:0]]] == mcc_pkg::StepMax;
            if (pol_r == mcc_pkg::PolicyLru && pos_r != '0) state_r <= S_SHIFT;
            else state_r <= S_DONE;
          end else begin
            pos_r <= pos_r + OW'(1);
          end
        end
        S_WALK: begin
          if (traj_r == 64'd1) begin
            state_r <= S_EVICT;
          end else if (tally_r == mcc_pkg::StepMax) begin
            sat_r <= 1'b1;
            state_r <= S_EVICT;
          end else if (!traj_r[0]) begin
            traj_r <= traj_r >> 1;
            tally_r <= tally_r + SW'(1);
          end else if (traj_r > mcc_pkg::TripleLimit) begin
            sat_r <= 1'b1;
            tally_r <= mcc_pkg::StepMax;
            state_r <= S_EVICT;
          end else begin
            traj_r <= traj_r + {traj_r[62:0], 1'b0} + 64'd1;
            tally_r <= tally_r + SW'(1);
          end
        end
        S_EVICT: begin
          if (occ_r >= cap_r && occ_r != '0) begin
            if (pol_r == mcc_pkg::PolicyLru) begin
              vld_r[ord_r[IW'(occ_r - OW'(1))]] <= 1'b0;
            end else begin
              vld_r[ord_r[0]] <= 1'b0;
              for (int i = 0; i < E - 1; i++) ord_r[i] <= ord_r[i + 1];
            end
            occ_r <= occ_r - OW'(1);
          end else begin
            slot_r <= free_slot;
            key_r[free_slot] <= num_r;
            stp_r[free_slot] <= tally_r;
            vld_r[free_slot] <= 1'b1;
            out_steps <= tally_r;
            out_saturated <= sat_r;
            pos_r <= occ_r;
            occ_r <= occ_r + OW'(1);
            if (ins_pos == occ_r) begin
              ord_r[IW'(occ_r)] <= free_slot;
              state_r <= S_DONE;
            end else begin
              state_r <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (pos_r == '0) begin
            ord_r[0] <= slot_r;
            state_r <= S_DONE;
          end else begin
            ord_r[pos_r[IW-1:0]] <= ord_r[IW'(pos_r - OW'(1))];
            pos_r <= pos_r - OW'(1);
          end
        end
        S_DONE: begin
          out_hit <= hit_r;
          out_hit_count <= hits_r;
          out_miss_count <= miss_r;
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/mcc_checker.sv =====
// port-level checker for the memo cache and its bind
`include "memoized_collatz_cache_assert.svh"
module mcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_steps,
  input logic        out_hit,
  input logic        out_saturated,
  input logic [31:0] out_hit_count
);
  `MCC_ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid, in_stall)
  `MCC_ASSERT_IMPL(a_sat_max, clk, rst_n, out_valid && out_hit && out_steps == 12'hFFF,
                   out_saturated)
  `MCC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_hit_count))
endmodule

bind memoized_collatz_cache mcc_checker u_mcc_checker (.*);

// ===== dv/memoized_collatz_cache_chk.sv =====
// checker for the memo cache: predicts each result and compares it with the block's output
`timescale 1ns / 1ps
module memoized_collatz_cache_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [30:0] in_number,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [11:0] out_steps,
  input  logic        out_hit,
  input  logic        out_saturated,
  input  logic [31:0] out_hit_count,
  input  logic [31:0] out_miss_count,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [4:0]  cfg_data,
  output int          errors,
  output int          pending
);
  localparam logic [63:0] TripleCap = (64'hFFFF_FFFF_FFFF_FFFF - 64'd1) / 64'd3;

  typedef struct packed {
    logic [30:0] key;
    logic [11:0] steps;
  } memo_t;

  typedef struct packed {
    logic [11:0] steps;
    logic        hit;
    logic        sat;
    logic [31:0] hits;
    logic [31:0] misses;
  } answer_t;

  memo_t   memo_q[$];
  answer_t answer_q[$];
  logic        lru;
  logic [4:0]  capacity;
  logic [31:0] hit_total;
  logic [31:0] miss_total;

  function automatic logic [11:0] trajectory_steps(input logic [30:0] n, output logic sat);
    logic [63:0] v;
    logic [11:0] t;
    v = 64'(n);
    t = '0;
    sat = 1'b0;
    while (v != 64'd1) begin
      if (t == mcc_pkg::StepMax) begin
        sat = 1'b1;
        break;
      end
      if (!v[0]) begin
        v = v >> 1;
      end else begin
        if (v > TripleCap) begin
          sat = 1'b1;
          t = mcc_pkg::StepMax;
          break;
        end
        v = v * 64'd3 + 64'd1;
      end
      t++;
    end
    return t;
  endfunction

  function automatic answer_t lookup_or_walk(input logic [30:0] n);
    answer_t a;
    memo_t   e;
    int      pos;
    int      cap;
    a = '0;
    if (n == '0) begin
      a.sat = 1'b1;
    end else begin
      pos = -1;
      foreach (memo_q[i]) begin
        if (pos < 0 && memo_q[i].key == n) pos = i;
      end
      if (pos >= 0) begin
        hit_total++;
        a.hit = 1'b1;
        a.steps = memo_q[pos].steps;
        a.sat = (a.steps == mcc_pkg::StepMax);
        if (lru && pos != 0) begin
          e = memo_q[pos];
          memo_q.delete(pos);
          memo_q.push_front(e);
        end
      end else begin
        miss_total++;
        a.steps = trajectory_steps(n, a.sat);
        cap = (capacity == 0) ? 1 :
              (capacity > mcc_pkg::Entries) ? mcc_pkg::Entries : int'(capacity);
        while (memo_q.size() >= cap && memo_q.size() > 0) begin
          if (lru) void'(memo_q.pop_back());
          else void'(memo_q.pop_front());
        end
        e.key = n;
        e.steps = a.steps;
        if (lru) memo_q.push_front(e);
        else memo_q.push_back(e);
      end
    end
    a.hits = hit_total;
    a.misses = miss_total;
    return a;
  endfunction

  assign pending = answer_q.size();

  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      memo_q.delete();
      answer_q.delete();
      lru <= 1'b1;
      capacity <= 5'd16;
      hit_total = '0;
      miss_total = '0;
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mcc_pkg::CfgPolicy) lru <= (cfg_data[0] == mcc_pkg::PolicyLru);
        else if (cfg_index == mcc_pkg::CfgEntries) capacity <= cfg_data;
      end
      if (in_valid && !in_stall) answer_q.push_back(lookup_or_walk(in_number));
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $error("result with no item pending");
          errors++;
        end else begin
          a = answer_q.pop_front();
          if (out_steps !== a.steps) begin
            $error("steps: expected %0d, got %0d", a.steps, out_steps);
            errors++;
          end
          if (out_hit !== a.hit) begin
            $error("hit: expected %0d, got %0d", a.hit, out_hit);
            errors++;
          end
          if (out_saturated !== a.sat) begin
            $error("saturated: expected %0d, got %0d", a.sat, out_saturated);
            errors++;
          end
          if (out_hit_count !== a.hits) begin
            $error("hit_count: expected %0d, got %0d", a.hits, out_hit_count);
            errors++;
          end
          if (out_miss_count !== a.misses) begin
            $error("miss_count: expected %0d, got %0d", a.misses, out_miss_count);
            errors++;
          end
        end
      end
    end
  end
endmodule

// ===== dv/memoized_collatz_cache_tb.sv =====
// testbench top for the memo cache: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module memoized_collatz_cache_tb;
  localparam int CycleLimit = 20000000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [30:0] in_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] out_steps;
  logic        out_hit;
  logic        out_saturated;
  logic [31:0] out_hit_count;
  logic [31:0] out_miss_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;
  int          errors;
  int          pending;
  int          cycles = 0;
  logic        quiet = 1'b0;
  logic [30:0] pool[24];

  memoized_collatz_cache i_dut (.*);
  memoized_collatz_cache_chk i_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_number(input logic [30:0] v);
    in_valid <= 1'b1;
    in_number <= v;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [30:0] directed[$];
    logic [4:0]  phase_policy[8];
    logic [4:0]  phase_cap[8];
    logic [30:0] v;
    phase_policy = '{5'd0, 5'd1, 5'd1, 5'd0, 5'd1, 5'd0, 5'd0, 5'd1};
    phase_cap    = '{5'd16, 5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17};
    foreach (pool[i]) pool[i] = (i < 12) ? 31'(i + 1) : 31'($urandom & 32'h7FFF_FFFF) | 31'd1;
    directed = '{31'd1, 31'd0, 31'h7FFF_FFFF, 31'd2, 31'd3, 31'd27, 31'd27, 31'd1,
                 31'h4000_0000, 31'h5555_5555, 31'h2AAA_AAAA, 31'd837799, 31'd2, 31'd3,
                 31'd0, 31'h7FFF_FFFF, 31'd6171, 31'd27};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(mcc_pkg::CfgPolicy, 5'd0);
    write_reg(mcc_pkg::CfgEntries, 5'd16);
    foreach (directed[i]) send_number(directed[i]);
    drain();
    for (int p = 0; p < 8; p++) begin
      write_reg(mcc_pkg::CfgPolicy, phase_policy[p]);
      write_reg(mcc_pkg::CfgEntries, phase_cap[p]);
      if (p == 7) quiet = 1'b1;
      for (int k = 0; k < 60; k++) begin
        if ($urandom_range(0, 9) < 6) v = pool[$urandom_range(0, 23)];
        else v = 31'($urandom);
        send_number(v);
        if (p == 2 && k == 30) drain();
      end
      drain();
    end
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
